### hdl/nmps_pkg.sv
// Shared types, constants and the mean divider of the neighbour mean smoother.
// Used by neighbour_mean_pixel_smoother_unit; no dependencies.
package nmps_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned PixW       = 3 * ChanW;
  localparam int unsigned SumW       = 11;
  localparam int unsigned ImgWidthW  = 11;
  localparam int unsigned ImgHeightW = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned ProdW      = 22;

  localparam logic [CfgIdxW-1:0]    REG_IMAGE_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0]    REG_IMAGE_HEIGHT = CfgIdxW'(1);
  localparam logic [ImgWidthW-1:0]  WidthReset       = ImgWidthW'(640);
  localparam logic [ImgHeightW-1:0] HeightReset      = ImgHeightW'(480);

  // reciprocals, exact for sums below 2048
  localparam logic [ProdW-1:0] Recip3 = ProdW'(683);
  localparam logic [ProdW-1:0] Recip5 = ProdW'(1639);
  localparam int unsigned      Shift3 = 11;
  localparam int unsigned      Shift5 = 13;

  typedef enum logic [1:0] {
    DIV3 = 2'd0,
    DIV5 = 2'd1,
    DIV8 = 2'd2
  } div_e;

  typedef struct packed {
    logic emit;
    logic last;
    logic miss_l;
    logic miss_r;
    logic miss_t;
    logic miss_b;
    logic fwd;
  } s1_ctrl_t;

  typedef struct packed {
    logic [SumW-1:0] r;
    logic [SumW-1:0] g;
    logic [SumW-1:0] b;
    div_e            div;
    logic            last;
  } sum_t;

  function automatic logic [ChanW-1:0] mean_div(logic [SumW-1:0] s, div_e d);
    logic [ProdW-1:0] p3;
    logic [ProdW-1:0] p5;
    logic [ChanW-1:0] q;
    p3 = ProdW'(s) * Recip3;
    p5 = ProdW'(s) * Recip5;
    case (d)
      DIV3:    q = ChanW'(p3 >> Shift3);
      DIV5:    q = ChanW'(p5 >> Shift5);
      default: q = ChanW'(s >> 3);
    endcase
    return q;
  endfunction

endpackage

### hdl/nmps_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module nmps_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/neighbour_mean_pixel_smoother_unit.sv
// Neighbour mean smoother top level: counters, row store RAMs, 3x3 window, divider.
// Depends on nmps_pkg and nmps_ram.
//
// Takes one RGB pixel per clock in raster order while in_stall_o is low and
// returns, per channel, the truncated mean of the pixel's in-image neighbours
// (centre excluded, divisor 3, 5 or 8). Results lag the input stream by one
// row plus one pixel, so after a frame the source sends image_width+1 pad
// beats; the result for the frame's last pixel carries frame_end and restarts
// the raster counters. Each beat costs one read and one write-back of each
// row store RAM, so one beat per clock is sustained while out_stall_i is
// low. The row stores need no clearing pass: unwritten entries only feed
// masked neighbours. Write image_width / image_height only while idle.
module neighbour_mean_pixel_smoother_unit
  import nmps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ChanW-1:0]    red_in_i,
  input  logic [ChanW-1:0]    green_in_i,
  input  logic [ChanW-1:0]    blue_in_i,
  input  logic                is_pad_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChanW-1:0]    red_avg_o,
  output logic [ChanW-1:0]    green_avg_o,
  output logic [ChanW-1:0]    blue_avg_o,
  output logic                frame_end_o
);

  localparam int unsigned ColW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW    = (WW > ImgWidthW) ? WW : ImgWidthW;
  localparam int unsigned InRowW  = ImgHeightW + 1;
  localparam int unsigned OutRowW = ImgHeightW;

  // configuration
  logic [ImgWidthW-1:0]  img_w_q;
  logic [ImgHeightW-1:0] img_h_q;
  logic [CmpW-1:0]       w_raw;
  logic [WW-1:0]         eff_w;
  logic [ImgHeightW-1:0] eff_h;

  // raster counters
  logic [ColW-1:0]    in_col_q, in_col_d;
  logic [InRowW-1:0]  in_row_q, in_row_d;
  logic [ColW-1:0]    out_col_q, out_col_d;
  logic [OutRowW-1:0] out_row_q, out_row_d;

  // handshake / pipeline
  logic     in_acc;
  logic     s1_valid_q;
  s1_ctrl_t s1_ctrl_q, s1_ctrl_d;
  logic [PixW-1:0] s1_pix_q, pix;
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] fwd_top_q, fwd_mid_q;
  logic     s2_valid_q;
  sum_t     s2_q, s2_d;
  logic     s2_ready, out_ready;
  logic     out_valid_q, frame_end_q;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  // RAM side
  logic            wr_en;
  logic [PixW-1:0] prev_rdata, prev2_rdata;
  logic [PixW-1:0] top_s1, mid_s1;

  // window
  logic [PixW-1:0] win_q [3][3];
  logic [PixW-1:0] nw    [3][3];

  always_comb begin
    w_raw = CmpW'(img_w_q);
    if (w_raw < CmpW'(2)) begin
      eff_w = WW'(2);
    end else if (w_raw > CmpW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(w_raw);
    end
    eff_h = (img_h_q < ImgHeightW'(2)) ? ImgHeightW'(2) : img_h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= WidthReset;
      img_h_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i[ImgWidthW-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i[ImgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = s1_valid_q && s2_ready;

  assign pix = is_pad_i ? '0 : {red_in_i, green_in_i, blue_in_i};

  // stage 0: counters, emit and neighbour masks
  always_comb begin
    logic [WW-1:0]      in_col_p1;
    logic [WW-1:0]      out_col_p1;
    logic [OutRowW:0]   out_row_p1;
    logic               col_end;
    logic               row_end;
    in_col_p1  = WW'(in_col_q) + WW'(1);
    out_col_p1 = WW'(out_col_q) + WW'(1);
    out_row_p1 = {1'b0, out_row_q} + (OutRowW + 1)'(1);
    col_end    = out_col_p1 >= eff_w;
    row_end    = out_row_p1 >= {1'b0, eff_h};

    s1_ctrl_d.emit   = (in_row_q >= InRowW'(2)) ||
                       ((in_row_q == InRowW'(1)) && (in_col_q != '0));
    s1_ctrl_d.last   = col_end && row_end;
    s1_ctrl_d.miss_l = out_col_q == '0;
    s1_ctrl_d.miss_r = col_end;
    s1_ctrl_d.miss_t = out_row_q == '0;
    s1_ctrl_d.miss_b = row_end;
    s1_ctrl_d.fwd    = wr_en && (s1_col_q == in_col_q);

    if (in_col_p1 >= eff_w) begin
      in_col_d = '0;
      in_row_d = in_row_q + InRowW'(1);
    end else begin
      in_col_d = ColW'(in_col_p1);
      in_row_d = in_row_q;
    end
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (s1_ctrl_d.emit) begin
      if (s1_ctrl_d.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (col_end) begin
        out_col_d = '0;
        out_row_d = out_row_q + OutRowW'(1);
      end else begin
        out_col_d = ColW'(out_col_p1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (in_acc) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // row stores: read on accept, write back as the beat leaves stage 1
  nmps_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (prev_rdata)
  );

  nmps_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_prev2_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_col_q),
    .wdata_i (mid_s1),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (prev2_rdata)
  );

  // same-column write-back in the read cycle bypasses the RAM
  assign top_s1 = s1_ctrl_q.fwd ? fwd_top_q : prev2_rdata;
  assign mid_s1 = s1_ctrl_q.fwd ? fwd_mid_q : prev_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_ctrl_q  <= s1_ctrl_d;
      end else if (s2_ready) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= pix;
      s1_col_q  <= in_col_q;
      fwd_top_q <= mid_s1;
      fwd_mid_q <= s1_pix_q;
    end
  end

  // stage 1: window shift and masked sums
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      for (int r = 0; r < 3; r++) begin
        nw[c][r] = win_q[c+1][r];
      end
    end
    nw[2][0] = top_s1;
    nw[2][1] = mid_s1;
    nw[2][2] = s1_pix_q;
  end

  always_comb begin
    logic use_px;
    logic miss_c;
    logic miss_r;
    s2_d.r = '0;
    s2_d.g = '0;
    s2_d.b = '0;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        use_px = !((dc == 0) && s1_ctrl_q.miss_l) && !((dc == 2) && s1_ctrl_q.miss_r) &&
                 !((dr == 0) && s1_ctrl_q.miss_t) && !((dr == 2) && s1_ctrl_q.miss_b) &&
                 !((dc == 1) && (dr == 1));
        if (use_px) begin
          s2_d.r = s2_d.r + SumW'(nw[dc][dr][3*ChanW-1:2*ChanW]);
          s2_d.g = s2_d.g + SumW'(nw[dc][dr][2*ChanW-1:ChanW]);
          s2_d.b = s2_d.b + SumW'(nw[dc][dr][ChanW-1:0]);
        end
      end
    end
    miss_c = s1_ctrl_q.miss_l || s1_ctrl_q.miss_r;
    miss_r = s1_ctrl_q.miss_t || s1_ctrl_q.miss_b;
    if (miss_c && miss_r) begin
      s2_d.div = DIV3;
    end else if (miss_c || miss_r) begin
      s2_d.div = DIV5;
    end else begin
      s2_d.div = DIV8;
    end
    s2_d.last = s1_ctrl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
      s2_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        win_q      <= nw;
        s2_valid_q <= s1_ctrl_q.emit;
      end else if (out_ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      s2_q <= s2_d;
    end
  end

  // stage 2: divide into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      red_q       <= mean_div(s2_q.r, s2_q.div);
      green_q     <= mean_div(s2_q.g, s2_q.div);
      blue_q      <= mean_div(s2_q.b, s2_q.div);
      frame_end_q <= s2_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_avg_o   = red_q;
  assign green_avg_o = green_q;
  assign blue_avg_o  = blue_q;
  assign frame_end_o = frame_end_q;

  // checks
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s1_ctrl_d.emit && s1_ctrl_d.last |=>
      in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0)
    else $error("frame end did not clear the raster counters");

  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s1_ctrl_d.fwd |-> s1_valid_q && wr_en)
    else $error("bypass taken without a write-back in the read cycle");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_ready |=> s2_valid_q && $stable(s2_q))
    else $error("sum stage changed while stalled");

  a_corner_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_q.div == DIV3 |->
      s2_q.r <= SumW'(765) && s2_q.g <= SumW'(765) && s2_q.b <= SumW'(765))
    else $error("corner sum covers more than three neighbours");

endmodule
